### design/mdi_pkg.sv
`default_nettype none
package mdi_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DIR_W    = 2;
  localparam int SPEED_W  = 24;
  localparam int VEL_W    = 40;
  localparam int ACC_W    = 48;
  localparam int DIGIT_SH_W = 16;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  localparam int MUL_DIGIT_W = 4;
  localparam int MUL_DIGITS  = 4;
  localparam int DEC_DIGIT_W = 3;
  localparam int DEC_DIGITS  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STILL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd4;

  localparam logic [15:0] RST_DEADBAND  = 16'd100;
  localparam logic [15:0] RST_STILL     = 16'd200;
  localparam logic [22:0] RST_DIR_LEVEL = 23'd100;
  localparam logic [15:0] RST_STEP_TIME = 16'd655;
  localparam logic [8:0]  RST_DECAY     = 9'd230;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_POS  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_NEG  = 2'd2;

  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef struct packed {
    logic [15:0] deadband_level;
    logic [15:0] still_level;
    logic [22:0] direction_level;
    logic [15:0] step_time_q16;
    logic [8:0]  decay_q8;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_OFFS,
    OP_LOAD,
    OP_ACC,
    OP_SUM,
    OP_MUL,
    OP_ADD,
    OP_DEC,
    OP_DFIN
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
  } lane_ctrl_t;

endpackage
`default_nettype wire

### design/mdi_in_if.sv
`default_nettype none
interface mdi_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mdi_pkg::SAMPLE_W-1:0]  sample_x;
  logic signed [mdi_pkg::SAMPLE_W-1:0]  sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface
`default_nettype wire

### design/mdi_out_if.sv
`default_nettype none
interface mdi_out_if;
  logic                                valid;
  logic                                ready;
  logic        [mdi_pkg::DIR_W-1:0]    dir_horizontal;
  logic        [mdi_pkg::DIR_W-1:0]    dir_vertical;
  logic signed [mdi_pkg::SPEED_W-1:0]  speed_x;
  logic signed [mdi_pkg::SPEED_W-1:0]  speed_y;

  modport source (output valid, output dir_horizontal, output dir_vertical,
                  output speed_x, output speed_y, input ready);
  modport sink   (input valid, input dir_horizontal, input dir_vertical,
                  input speed_x, input speed_y, output ready);
endinterface
`default_nettype wire

### design/mdi_cfg_regs.sv
`default_nettype none
module mdi_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mdi_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [mdi_pkg::CFG_DATA_W-1:0]    pwdata,
  output      logic [mdi_pkg::CFG_DATA_W-1:0]    prdata,
  output      logic                              pready,
  output      mdi_pkg::cfg_t                     cfg
);

  mdi_pkg::cfg_t                  cfg_r;
  logic [mdi_pkg::CFG_IDX_W-1:0]  idx;
  logic                           wr_en;

  assign idx    = paddr[mdi_pkg::CFG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband_level  <= mdi_pkg::RST_DEADBAND;
      cfg_r.still_level     <= mdi_pkg::RST_STILL;
      cfg_r.direction_level <= mdi_pkg::RST_DIR_LEVEL;
      cfg_r.step_time_q16   <= mdi_pkg::RST_STEP_TIME;
      cfg_r.decay_q8        <= mdi_pkg::RST_DECAY;
    end else if (wr_en) begin
      case (idx)
        mdi_pkg::REG_DEADBAND:  cfg_r.deadband_level  <= pwdata[15:0];
        mdi_pkg::REG_STILL:     cfg_r.still_level     <= pwdata[15:0];
        mdi_pkg::REG_DIR_LEVEL: cfg_r.direction_level <= pwdata[22:0];
        mdi_pkg::REG_STEP_TIME: cfg_r.step_time_q16   <= pwdata[15:0];
        mdi_pkg::REG_DECAY:     cfg_r.decay_q8        <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mdi_pkg::REG_DEADBAND:  prdata = 32'(cfg_r.deadband_level);
      mdi_pkg::REG_STILL:     prdata = 32'(cfg_r.still_level);
      mdi_pkg::REG_DIR_LEVEL: prdata = 32'(cfg_r.direction_level);
      mdi_pkg::REG_STEP_TIME: prdata = 32'(cfg_r.step_time_q16);
      mdi_pkg::REG_DECAY:     prdata = 32'(cfg_r.decay_q8);
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/mdi_axis.sv
`default_nettype none
module mdi_axis #(
  parameter int VEL_FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire mdi_pkg::lane_ctrl_t                  ctrl,
  input  wire mdi_pkg::cfg_t                        cfg,
  input  wire logic [mdi_pkg::SAMPLE_W-1:0]         sample,
  output      logic [mdi_pkg::DIR_W-1:0]            dir,
  output      logic [mdi_pkg::SPEED_W-1:0]          speed
);

  localparam int F  = VEL_FRAC_BITS;
  localparam int VW = mdi_pkg::VEL_W;
  localparam int AW = mdi_pkg::ACC_W;
  localparam int IW = 34 + ((F > 17) ? (F - 17) : 0);
  localparam int SW = ((IW > VW) ? IW : VW) + 2;
  localparam int LW = 23 + F;
  localparam int CW = ((LW > VW) ? LW : VW) + 2;

  logic [15:0]    off_r, samp_r;
  logic [16:0]    az_r, azmag_r, last_r;
  logic [17:0]    smag_r;
  logic           neg_r, still_r;
  logic [AW-1:0]  acc_r;
  logic [mdi_pkg::DIGIT_SH_W-1:0] sh_r;
  logic [VW-1:0]  vel_r;

  // offset correction and deadband
  logic [16:0] a_diff, a_mag;
  logic        in_dead;
  assign a_diff  = {samp_r[15], samp_r} - {off_r[15], off_r};
  assign a_mag   = a_diff[16] ? (~a_diff + 17'd1) : a_diff;
  assign in_dead = a_mag < {1'b0, cfg.deadband_level};

  // trapezoid sum
  logic [17:0] s_sum, s_mag;
  assign s_sum = {az_r[16], az_r} + {last_r[16], last_r};
  assign s_mag = s_sum[17] ? (~s_sum + 18'd1) : s_sum;

  // digit products
  logic [21:0]    pp_m;
  logic [VW-1:0]  vmag;
  logic [42:0]    pp_d;
  assign pp_m = 22'(smag_r) * 22'(sh_r[15:12]);
  assign vmag = vel_r[VW-1] ? (~vel_r + VW'(1)) : vel_r;
  assign pp_d = 43'(vmag) * 43'(sh_r[15:13]);

  // increment scaling and saturating add
  logic [IW-1:0] inc_mag;
  if (F >= 17) begin : g_inc_up
    assign inc_mag = IW'(acc_r[33:0]) << (F - 17);
  end else begin : g_inc_dn
    assign inc_mag = IW'(acc_r[33:0] >> (17 - F));
  end

  logic [SW-1:0] inc_e, inc_s, vel_e, tot;
  logic          tot_ovf;
  logic [VW-1:0] vel_add;
  assign inc_e   = SW'(inc_mag);
  assign inc_s   = neg_r ? (~inc_e + SW'(1)) : inc_e;
  assign vel_e   = {{(SW-VW){vel_r[VW-1]}}, vel_r};
  assign tot     = vel_e + inc_s;
  assign tot_ovf = !((&tot[SW-1:VW-1]) || !(|tot[SW-1:VW-1]));
  assign vel_add = tot_ovf ? (tot[SW-1] ? mdi_pkg::VEL_MIN : mdi_pkg::VEL_MAX)
                           : tot[VW-1:0];

  // decay result
  logic [VW-1:0] dres, vel_dec;
  assign dres = acc_r[AW-1:8];
  always_comb begin
    if (!vel_r[VW-1]) begin
      vel_dec = dres[VW-1] ? mdi_pkg::VEL_MAX : dres;
    end else begin
      vel_dec = (dres[VW-1] && |dres[VW-2:0]) ? mdi_pkg::VEL_MIN : (~dres + VW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      last_r <= '0;
      vel_r  <= '0;
    end else begin
      case (ctrl.op)
        mdi_pkg::OP_OFFS: off_r <= sample;
        mdi_pkg::OP_LOAD: samp_r <= sample;
        mdi_pkg::OP_ACC: begin
          az_r    <= in_dead ? 17'd0 : a_diff;
          azmag_r <= in_dead ? 17'd0 : a_mag;
        end
        mdi_pkg::OP_SUM: begin
          neg_r   <= s_sum[17];
          smag_r  <= s_mag;
          last_r  <= az_r;
          still_r <= azmag_r < {1'b0, cfg.still_level};
          acc_r   <= '0;
          sh_r    <= cfg.step_time_q16;
        end
        mdi_pkg::OP_MUL: begin
          acc_r <= (acc_r << mdi_pkg::MUL_DIGIT_W) + AW'(pp_m);
          sh_r  <= sh_r << mdi_pkg::MUL_DIGIT_W;
        end
        mdi_pkg::OP_ADD: begin
          vel_r <= vel_add;
          acc_r <= '0;
          sh_r  <= {cfg.decay_q8, 7'd0};
        end
        mdi_pkg::OP_DEC: begin
          acc_r <= (acc_r << mdi_pkg::DEC_DIGIT_W) + AW'(pp_d);
          sh_r  <= sh_r << mdi_pkg::DEC_DIGIT_W;
        end
        mdi_pkg::OP_DFIN: if (still_r) vel_r <= vel_dec;
        default: ;
      endcase
    end
  end

  // direction and integer speed from the current velocity
  logic signed [CW-1:0] vel_c, lim_c;
  logic [LW-1:0]        lim;
  assign lim   = {cfg.direction_level, {F{1'b0}}};
  assign vel_c = CW'($signed(vel_r));
  assign lim_c = $signed(CW'(lim));
  assign dir   = (vel_c > lim_c) ? mdi_pkg::DIR_POS :
                 (vel_c < -lim_c) ? mdi_pkg::DIR_NEG : mdi_pkg::DIR_NONE;

  logic [VW-1:0] spd_mag;
  assign spd_mag = vmag >> F;
  always_comb begin
    if (!vel_r[VW-1]) begin
      speed = (spd_mag > VW'(24'h7FFFFF)) ? 24'h7FFFFF : spd_mag[23:0];
    end else begin
      speed = (spd_mag > VW'(24'h800000)) ? 24'h800000 : (~spd_mag[23:0] + 24'd1);
    end
  end

endmodule
`default_nettype wire

### design/motion_direction_integrator_top.sv
`default_nettype none
// Each accepted input word passes through the sequencer steps in order: the accept,
// the offset and sum steps, the four-digit step-time multiply, the add, the three-digit
// decay multiply, the decay commit and the output load; a result word left waiting
// holds the load back. No new word is taken until the last one has been loaded out.
// The first word after reset only loads the offsets and gives no result word.
// Reset: rst_n synchronous, active low; registers return to defaults, velocity,
// offsets and last acceleration clear, no clearing pass is needed.
module motion_direction_integrator_top #(
  parameter int VEL_FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  mdi_in_if.sink                                 in_ch,
  mdi_out_if.source                              out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mdi_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [mdi_pkg::CFG_DATA_W-1:0]    pwdata,
  output      logic [mdi_pkg::CFG_DATA_W-1:0]    prdata,
  output      logic                              pready
);

  // sequencer states: one step of the per-axis datapath each
  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_SUM,
    S_MUL,
    S_ADD,
    S_DEC,
    S_DFIN,
    S_OUT
  } state_t;

  state_t                        state_r;
  logic [1:0]                    cnt_r;
  logic                          offs_taken_r;
  logic                          out_valid_r;
  logic [mdi_pkg::DIR_W-1:0]     dir_h_r, dir_v_r;
  logic [mdi_pkg::SPEED_W-1:0]   speed_x_r, speed_y_r;

  mdi_pkg::cfg_t                 cfg;
  mdi_pkg::lane_ctrl_t           ctrl;
  logic                          in_acc;
  logic                          out_load;
  logic [mdi_pkg::DIR_W-1:0]     dir_x, dir_y;
  logic [mdi_pkg::SPEED_W-1:0]   spd_x, spd_y;

  // take a word only between items; the output register parts the two sides
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.dir_horizontal = dir_h_r;
  assign out_ch.dir_vertical   = dir_v_r;
  assign out_ch.speed_x        = speed_x_r;
  assign out_ch.speed_y        = speed_y_r;

  mdi_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // drive both axis lanes in lock step from the current state
  always_comb begin
    case (state_r)
      S_IDLE: begin
        if (!in_acc) begin
          ctrl.op = mdi_pkg::OP_NONE;
        end else if (!offs_taken_r) begin
          ctrl.op = mdi_pkg::OP_OFFS;
        end else begin
          ctrl.op = mdi_pkg::OP_LOAD;
        end
      end
      S_ACC:  ctrl.op = mdi_pkg::OP_ACC;
      S_SUM:  ctrl.op = mdi_pkg::OP_SUM;
      S_MUL:  ctrl.op = mdi_pkg::OP_MUL;
      S_ADD:  ctrl.op = mdi_pkg::OP_ADD;
      S_DEC:  ctrl.op = mdi_pkg::OP_DEC;
      S_DFIN: ctrl.op = mdi_pkg::OP_DFIN;
      default: ctrl.op = mdi_pkg::OP_NONE;
    endcase
  end

  mdi_axis #(.VEL_FRAC_BITS(VEL_FRAC_BITS)) u_axis_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .sample (in_ch.sample_x),
    .dir    (dir_x),
    .speed  (spd_x)
  );

  mdi_axis #(.VEL_FRAC_BITS(VEL_FRAC_BITS)) u_axis_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .sample (in_ch.sample_y),
    .dir    (dir_y),
    .speed  (spd_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      offs_taken_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // raise the result word on load, drop it once the sink takes it
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!offs_taken_r) begin
              offs_taken_r <= 1'b1;
            end else begin
              state_r <= S_ACC;
            end
          end
        end
        S_ACC: state_r <= S_SUM;
        S_SUM: begin
          cnt_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          // advance one step-time digit per cycle, most significant first
          if (cnt_r == 2'(mdi_pkg::MUL_DIGITS - 1)) begin
            state_r <= S_ADD;
          end else begin
            cnt_r <= cnt_r + 2'd1;
          end
        end
        S_ADD: begin
          cnt_r   <= '0;
          state_r <= S_DEC;
        end
        S_DEC: begin
          // the decay digits run every item; each lane commits only when still
          if (cnt_r == 2'(mdi_pkg::DEC_DIGITS - 1)) begin
            state_r <= S_DFIN;
          end else begin
            cnt_r <= cnt_r + 2'd1;
          end
        end
        S_DFIN: state_r <= S_OUT;
        S_OUT: begin
          // hold here while an earlier word still waits at the output
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_load) begin
        dir_h_r   <= dir_x;
        dir_v_r   <= dir_y;
        speed_x_r <= spd_x;
        speed_y_r <= spd_y;
      end
    end
  end

  a_mul_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && cnt_r == 2'(mdi_pkg::MUL_DIGITS - 1)) |=> (state_r == S_ADD))
    else $error("step multiply did not end after its last digit");

  a_dec_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC && cnt_r == 2'(mdi_pkg::DEC_DIGITS - 1)) |=> (state_r == S_DFIN))
    else $error("decay multiply did not end after its last digit");

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word raised outside the output state");

  a_no_result_before_offset: assert property (@(posedge clk) disable iff (!rst_n)
    !offs_taken_r |-> (!out_valid_r && state_r == S_IDLE))
    else $error("work started before the offsets were taken");

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the two-axis motion integrator. A queue of sample words
// feeds a falling-edge driver; a rising-edge monitor predicts each accepted sample
// and checks every result word against the oldest prediction.
module tb_top;

  localparam int FRAC_BITS    = 16;     // matches the default VEL_FRAC_BITS of the block
  localparam int DRAIN_CYCLES = 24;     // settle time after the queues have drained
  localparam int STALL_LEN    = 400;    // long receiver hold-off, fills the pipeline
  localparam int IDLE_LIMIT   = 4000;   // cycles with no accepted word before giving up
  localparam longint VEL_TOP    = (longint'(1) <<< 39) - 1;
  localparam longint VEL_BOTTOM = -(longint'(1) <<< 39);

  typedef struct packed {
    logic signed [mdi_pkg::SAMPLE_W-1:0] sx;
    logic signed [mdi_pkg::SAMPLE_W-1:0] sy;
  } motion_sample_t;

  typedef struct packed {
    logic [mdi_pkg::DIR_W-1:0]          dir_h;
    logic [mdi_pkg::DIR_W-1:0]          dir_v;
    logic signed [mdi_pkg::SPEED_W-1:0] speed_x;
    logic signed [mdi_pkg::SPEED_W-1:0] speed_y;
  } motion_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [mdi_pkg::CFG_ADDR_W-1:0] paddr;
  logic [mdi_pkg::CFG_DATA_W-1:0] pwdata;
  logic [mdi_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  mdi_in_if  in_ch ();
  mdi_out_if out_ch ();

  motion_direction_integrator_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Words waiting to be offered, and result words predicted but not yet seen.
  motion_sample_t samples_pending[$];
  motion_result_t motion_results_due[$];

  int send_idle_pct = 29;
  int recv_idle_pct = 58;
  int stall_req     = 0;   // bumped by the stimulus to ask for a long hold-off
  int stall_seen    = 0;   // owned by the receiver process
  int stall_left    = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  logic in_fired = 1'b0;   // input word accepted at the last rising edge

  // Predictor state: the block's own registers and per-axis integrator.
  mdi_pkg::cfg_t cfg_now;
  bit     have_zero;
  int     zero_x, zero_y;
  int     last_acc_x, last_acc_y;
  longint vel_x_now, vel_y_now;

  // Keep every input at a known level from time zero; hold reset low, then release it.
  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid    = 1'b0;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    out_ch.ready   = 1'b0;
    cfg_now    = '{mdi_pkg::RST_DEADBAND, mdi_pkg::RST_STILL, mdi_pkg::RST_DIR_LEVEL,
                   mdi_pkg::RST_STEP_TIME, mdi_pkg::RST_DECAY};
    have_zero  = 1'b0;
    zero_x     = 0;
    zero_y     = 0;
    last_acc_x = 0;
    last_acc_y = 0;
    vel_x_now  = 0;
    vel_y_now  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint shift_to_zero(longint v, int n);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >> n;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp_vel(longint v);
    if (v > VEL_TOP) return VEL_TOP;
    if (v < VEL_BOTTOM) return VEL_BOTTOM;
    return v;
  endfunction

  function automatic logic signed [mdi_pkg::SAMPLE_W-1:0] clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[mdi_pkg::SAMPLE_W-1:0];
  endfunction

  // One trapezoid step of an axis: offset, deadband, integrate, then decay when still.
  task automatic integrate_axis(input int sample, input int zero, inout int last_acc,
                                inout longint vel);
    longint acc, acc_mag, prod, inc;
    acc = sample - zero;
    acc_mag = (acc < 0) ? -acc : acc;
    if (acc_mag < longint'(cfg_now.deadband_level)) acc = 0;
    prod = (acc + last_acc) * longint'(cfg_now.step_time_q16);
    if (FRAC_BITS >= 17) inc = prod <<< (FRAC_BITS - 17);
    else inc = shift_to_zero(prod, 17 - FRAC_BITS);
    vel = clamp_vel(vel + inc);
    last_acc = int'(acc);
    acc_mag = (acc < 0) ? -acc : acc;
    if (acc_mag < longint'(cfg_now.still_level))
      vel = clamp_vel(shift_to_zero(vel * longint'(cfg_now.decay_q8), 8));
  endtask

  function automatic logic [mdi_pkg::DIR_W-1:0] heading_of(longint vel);
    longint lim;
    lim = longint'(cfg_now.direction_level) <<< FRAC_BITS;
    if (vel > lim) return mdi_pkg::DIR_POS;
    if (vel < -lim) return mdi_pkg::DIR_NEG;
    return mdi_pkg::DIR_NONE;
  endfunction

  function automatic logic signed [mdi_pkg::SPEED_W-1:0] speed_of(longint vel);
    longint s;
    s = shift_to_zero(vel, FRAC_BITS);
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    return s[mdi_pkg::SPEED_W-1:0];
  endfunction

  // Advance the integrator by one accepted sample word; the first one only sets zero.
  task automatic advance_motion(input int sx, input int sy);
    motion_result_t r;
    if (!have_zero) begin
      have_zero = 1'b1;
      zero_x = sx;
      zero_y = sy;
    end else begin
      integrate_axis(sx, zero_x, last_acc_x, vel_x_now);
      integrate_axis(sy, zero_y, last_acc_y, vel_y_now);
      r.dir_h   = heading_of(vel_x_now);
      r.dir_v   = heading_of(vel_y_now);
      r.speed_x = speed_of(vel_x_now);
      r.speed_y = speed_of(vel_y_now);
      motion_results_due.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- driver

  // Hold the current word until it is taken, then offer the next one or idle.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_fired) begin
        if (samples_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          motion_sample_t w;
          w = samples_pending.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.sample_x <= w.sx;
          in_ch.sample_y <= w.sy;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_req != stall_seen) begin
      stall_seen   <= stall_req;
      stall_left   <= STALL_LEN - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  // Check the result word first, then predict from the input word taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      in_fired <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (motion_results_due.size() == 0) begin
          $display("%0t: result word with none due: dir %0d/%0d speed %0d/%0d", $time,
                   out_ch.dir_horizontal, out_ch.dir_vertical,
                   $signed(out_ch.speed_x), $signed(out_ch.speed_y));
          mismatch_count++;
        end else begin
          motion_result_t e;
          e = motion_results_due.pop_front();
          if (out_ch.dir_horizontal !== e.dir_h) begin
            $display("%0t: dir_horizontal expected %0d actual %0d", $time,
                     e.dir_h, out_ch.dir_horizontal);
            mismatch_count++;
          end
          if (out_ch.dir_vertical !== e.dir_v) begin
            $display("%0t: dir_vertical expected %0d actual %0d", $time,
                     e.dir_v, out_ch.dir_vertical);
            mismatch_count++;
          end
          if (out_ch.speed_x !== e.speed_x) begin
            $display("%0t: speed_x expected %0d actual %0d", $time,
                     e.speed_x, $signed(out_ch.speed_x));
            mismatch_count++;
          end
          if (out_ch.speed_y !== e.speed_y) begin
            $display("%0t: speed_y expected %0d actual %0d", $time,
                     e.speed_y, $signed(out_ch.speed_y));
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        advance_motion(int'(in_ch.sample_x), int'(in_ch.sample_y));
    end
  end

  // Watchdog: give up when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  task automatic push_sample(input int x, input int y);
    samples_pending.push_back('{clip16(x), clip16(y)});
  endtask

  // Wait for every word to be taken and every result to land, then let the pipe empty.
  task automatic wait_drained();
    do @(posedge clk);
    while (samples_pending.size() != 0 || in_ch.valid || motion_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; mirror the register once the access completes.
  task automatic write_reg(input logic [mdi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      mdi_pkg::REG_DEADBAND:  cfg_now.deadband_level  = value[15:0];
      mdi_pkg::REG_STILL:     cfg_now.still_level     = value[15:0];
      mdi_pkg::REG_DIR_LEVEL: cfg_now.direction_level = value[22:0];
      mdi_pkg::REG_STEP_TIME: cfg_now.step_time_q16   = value[15:0];
      mdi_pkg::REG_DECAY:     cfg_now.decay_q8        = value[8:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int dead, input int still, input int dir_lvl,
                           input int step, input int decay);
    write_reg(mdi_pkg::REG_DEADBAND, dead);
    write_reg(mdi_pkg::REG_STILL, still);
    write_reg(mdi_pkg::REG_DIR_LEVEL, dir_lvl);
    write_reg(mdi_pkg::REG_STEP_TIME, step);
    write_reg(mdi_pkg::REG_DECAY, decay);
  endtask

  // Random motion in runs: sustained pushes around the zero point dominate, with
  // stretches near rest (deadband and still region) and some full-range noise.
  task automatic queue_motion(input int count);
    int left, run, mode, push_x, push_y, x, y;
    left = count;
    while (left > 0) begin
      run = $urandom_range(24, 1);
      if (run > left) run = left;
      mode = $urandom_range(9, 0);
      push_x = int'($urandom_range(65535, 0)) - 32768;
      push_y = int'($urandom_range(65535, 0)) - 32768;
      for (int k = 0; k < run; k++) begin
        if (mode < 2) begin
          x = int'($urandom_range(65535, 0)) - 32768;
          y = int'($urandom_range(65535, 0)) - 32768;
        end else if (mode < 5) begin
          x = zero_x + int'($urandom_range(600, 0)) - 300;
          y = zero_y + int'($urandom_range(600, 0)) - 300;
        end else begin
          x = zero_x + push_x + int'($urandom_range(512, 0)) - 256;
          y = zero_y + push_y + int'($urandom_range(512, 0)) - 256;
        end
        push_sample(x, y);
      end
      left -= run;
    end
  endtask

  // ---------------------------------------------------------------- test sequence

  initial begin
    @(posedge rst_n);

    // Defaults written back explicitly; writes to unused indexes must change nothing.
    write_all(int'(mdi_pkg::RST_DEADBAND), int'(mdi_pkg::RST_STILL),
              int'(mdi_pkg::RST_DIR_LEVEL), int'(mdi_pkg::RST_STEP_TIME),
              int'(mdi_pkg::RST_DECAY));
    for (int i = mdi_pkg::REG_DECAY + 1; i < 2 ** mdi_pkg::CFG_IDX_W; i++)
      write_reg(i[mdi_pkg::CFG_IDX_W-1:0], $urandom);

    // Directed: the zero point at opposite extremes so the corrected value spans 17 bits.
    push_sample(-32768, 32767);             // first word: zero point only, no result
    push_sample(-32768, 32767);             // exactly at zero
    push_sample(32767, -32768);             // largest corrected magnitude, both signs
    push_sample(-32768 + 99, 32767 - 99);   // just inside the deadband
    push_sample(-32768 + 100, 32767 - 100); // on the deadband edge, below still level
    push_sample(-32768 + 199, 32767 - 199); // just below the still level
    push_sample(-32768 + 200, 32767 - 200); // on the still edge: no decay
    push_sample(0, 0);
    push_sample(-1, 1);
    push_sample(1, -1);
    repeat (4) push_sample(32767, -32768);  // build speed past the direction level
    repeat (2) push_sample(-32768, 32767);  // still again: decay
    repeat (3) push_sample(-32768 + 32768, 32767 - 32767);
    push_sample(32767, 32767);
    push_sample(-32768, -32768);
    wait_drained();

    queue_motion(200);
    wait_drained();

    // Fastest integration, no deadband, no decay, zero level: drive both axes into
    // saturation of opposite sign, with a long hold-off on the result side meanwhile.
    write_all(0, 0, 0, 65535, 256);
    repeat (140) push_sample(32767, -32768);
    stall_req++;
    wait_drained();
    // Sender paused until all due results came back; carry on at saturation.
    repeat (20) push_sample(32767, -32768);
    queue_motion(60);
    wait_drained();

    // Everything counts as still, growth factor above one: velocity saturates;
    // the largest direction level.
    send_idle_pct = 58;
    recv_idle_pct = 29;
    write_all(65535, 65535, 8388607, 65535, 511);
    repeat (10) push_sample(zero_x, zero_y);
    queue_motion(140);
    wait_drained();

    // Decay to nothing whenever still; tiny step time.
    write_all(50, 65535, 1, 1, 0);
    queue_motion(150);
    wait_drained();

    // Random settings: full ranges for step time and decay, limited ranges for the levels.
    for (int p = 0; p < 4; p++) begin
      if (p >= 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_all($urandom_range(400, 0), $urandom_range(2000, 0), $urandom_range(3000, 0),
                $urandom_range(65535, 0), $urandom_range(511, 0));
      queue_motion(120);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
